FILE: design/assert_macros.svh
// Assertion macros used by the port-level checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication that must hold in the same cycle.
`define ASSERT_SAME(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Implication that must hold in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

FILE: design/mrf_pkg.sv
// Shared types, constants and the CRC byte update for the Modbus RTU response framer.
// No dependencies.
package mrf_pkg;

   localparam int TABLE_DEPTH_DEF = 256;
   localparam int COUNT_LIMIT     = 110;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_READ  = 2'd1,
      OP_WRITE = 2'd2
   } op_type;

   typedef struct packed {
      logic capture;
      logic clear_step;
      logic reduce_step;
      logic mem_write;
      logic idx_load;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic reduce_last;
      logic count_over;
      logic frame_done;
   } status_type;

   // CRC-16/MODBUS update over one byte, LSB first.
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc_i,
                                              input logic [7:0]  data_i);
      logic [15:0] c;
      c = crc_i ^ {8'h00, data_i};
      for (int b = 0; b < 8; b++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

FILE: design/mrf_ctrl.sv
// Sequencer for the Modbus RTU response framer: clear pass, index reduction,
// table write and byte emission. Depends on mrf_pkg.
module mrf_ctrl import mrf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_operation,
   input  status_type status,
   output cmd_type    cmd,
   output logic       req_stall
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_REDUCE,
      ST_POST,
      ST_EMIT
   } state_type;

   state_type state_ff;
   logic      is_load_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         is_load_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_CLEAR: begin
               if (status.clear_last) state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (req_valid) begin
                  is_load_ff <= (req_operation == OP_LOAD);
                  unique case (req_operation)
                     OP_LOAD:  state_ff <= ST_REDUCE;
                     OP_READ:  state_ff <= status.count_over ? ST_IDLE : ST_REDUCE;
                     OP_WRITE: state_ff <= ST_EMIT;
                     default:  state_ff <= ST_IDLE;
                  endcase
               end
            end
            ST_REDUCE: begin
               if (status.reduce_last) state_ff <= ST_POST;
            end
            ST_POST: begin
               state_ff <= is_load_ff ? ST_IDLE : ST_EMIT;
            end
            ST_EMIT: begin
               if (status.frame_done) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_CLEAR;
         endcase
      end
   end

   always_comb begin
      cmd.capture     = (state_ff == ST_IDLE) && req_valid;
      cmd.clear_step  = (state_ff == ST_CLEAR);
      cmd.reduce_step = (state_ff == ST_REDUCE);
      cmd.mem_write   = (state_ff == ST_POST) && is_load_ff;
      cmd.idx_load    = (state_ff == ST_POST) && !is_load_ff;
      cmd.emit        = (state_ff == ST_EMIT);
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

FILE: design/mrf_dp.sv
// Datapath of the Modbus RTU response framer: request registers, table memory,
// modulo reduction, byte select, CRC, packer and output register. Depends on mrf_pkg.
module mrf_dp import mrf_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output status_type  status,
   input  logic [1:0]  req_operation,
   input  logic [7:0]  req_slave_address,
   input  logic [7:0]  req_function_code,
   input  logic [15:0] req_start_address,
   input  logic [15:0] req_register_count,
   input  logic [7:0]  req_load_index,
   input  logic [15:0] req_load_value,
   input  logic        rsp_stall,
   output logic        rsp_valid,
   output logic [31:0] rsp_frame_bytes,
   output logic [2:0]  rsp_valid_bytes,
   output logic        rsp_end_of_frame
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_DEPTH - 1);
   // ceil(2^32 / depth): exact quotient for any 16-bit index
   localparam logic [31:0] RECIP =
      32'(((64'd1 << 32) + 64'(TABLE_DEPTH) - 64'd1) / 64'(TABLE_DEPTH));
   localparam logic [16:0] DEPTH_W = 17'(TABLE_DEPTH);

   // request registers
   logic [7:0]  addr_ff, func_ff;
   logic [15:0] start_ff, count_ff, value_ff;
   logic        is_read_ff;
   logic [7:0]  len_ff, pos_ff;
   logic [15:0] crc_ff;

   // modulo reduction
   logic [15:0] mod_ff;
   logic        step_ff;
   logic [15:0] quot_ff, quot_in, qd;

   // table
   logic [15:0]      mem [TABLE_DEPTH];
   logic [IDX_W-1:0] clr_idx_ff, rd_idx_ff, rd_idx_in, wr_addr;
   logic [15:0]      rd_data_ff, wr_data;
   logic             mem_we;

   // emission and packing
   logic [7:0]  cur_byte;
   logic        data_byte, frame_last, byte_go, advance, out_free, flush;
   logic [31:0] pack_ff, word_in;
   logic [1:0]  pack_cnt_ff;
   logic [2:0]  cnt_next;
   logic [4:0]  shamt;
   logic        out_valid_ff, out_eof_ff;
   logic [31:0] out_bytes_ff;
   logic [2:0]  out_cnt_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         addr_ff    <= req_slave_address;
         func_ff    <= req_function_code;
         start_ff   <= req_start_address;
         count_ff   <= req_register_count;
         value_ff   <= req_load_value;
         is_read_ff <= (req_operation == OP_READ);
         len_ff     <= (req_operation == OP_READ) ?
                       8'd3 + {req_register_count[6:0], 1'b0} : 8'd6;
      end
   end

   // Reduce the index by the table depth in two steps: quotient by reciprocal
   // multiply, then subtract quotient times depth.
   assign quot_in = 16'((48'(mod_ff) * 48'(RECIP)) >> 32);
   assign qd      = 16'(quot_ff * DEPTH_W);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mod_ff  <= (req_operation == OP_LOAD) ? {8'h00, req_load_index}
                                                : req_start_address;
         step_ff <= 1'b0;
      end else if (cmd.reduce_step) begin
         if (step_ff) begin
            mod_ff <= mod_ff - qd;
         end else begin
            quot_ff <= quot_in;
         end
         step_ff <= 1'b1;
      end
   end

   // Byte select over the frame position.
   assign data_byte  = (pos_ff < len_ff);
   assign frame_last = (pos_ff == len_ff + 8'd1);

   always_comb begin
      priority if (pos_ff == 8'd0) begin
         cur_byte = addr_ff;
      end else if (pos_ff == 8'd1) begin
         cur_byte = func_ff;
      end else if (pos_ff == len_ff) begin
         cur_byte = crc_ff[7:0];
      end else if (frame_last) begin
         cur_byte = crc_ff[15:8];
      end else if (!is_read_ff) begin
         unique case (pos_ff[1:0])
            2'd2: cur_byte = start_ff[15:8];
            2'd3: cur_byte = start_ff[7:0];
            2'd0: cur_byte = count_ff[15:8];
            2'd1: cur_byte = count_ff[7:0];
         endcase
      end else if (pos_ff == 8'd2) begin
         cur_byte = {count_ff[6:0], 1'b0};
      end else begin
         cur_byte = pos_ff[0] ? rd_data_ff[15:8] : rd_data_ff[7:0];
      end
   end

   assign out_free = !out_valid_ff || !rsp_stall;
   assign byte_go  = cmd.emit && out_free;
   // Step to the next table word after its low byte.
   assign advance  = byte_go && is_read_ff && data_byte && (pos_ff > 8'd2) && !pos_ff[0];

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         crc_ff <= CRC_INIT;
         pos_ff <= 8'd0;
      end else if (byte_go) begin
         if (data_byte) crc_ff <= crc16_byte(crc_ff, cur_byte);
         pos_ff <= pos_ff + 8'd1;
      end
   end

   // Table memory: one write port, one registered read port.
   always_comb begin
      if (cmd.idx_load) begin
         rd_idx_in = mod_ff[IDX_W-1:0];
      end else if (advance) begin
         rd_idx_in = (rd_idx_ff == IDX_LAST) ? '0 : rd_idx_ff + 1'b1;
      end else begin
         rd_idx_in = rd_idx_ff;
      end
   end

   assign mem_we  = cmd.clear_step || cmd.mem_write;
   assign wr_addr = cmd.clear_step ? clr_idx_ff : mod_ff[IDX_W-1:0];
   assign wr_data = cmd.clear_step ? 16'h0000 : value_ff;

   always_ff @(posedge clock) begin
      if (mem_we) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_idx_in];
      rd_idx_ff  <= rd_idx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_idx_ff <= '0;
      end else if (cmd.clear_step) begin
         clr_idx_ff <= clr_idx_ff + 1'b1;
      end
   end

   // Packer: append bytes MSB lane first, hand off at four bytes or frame end.
   assign shamt    = 5'd24 - {pack_cnt_ff, 3'b000};
   assign word_in  = pack_ff | ({24'h000000, cur_byte} << shamt);
   assign cnt_next = {1'b0, pack_cnt_ff} + 3'd1;
   assign flush    = byte_go && ((pack_cnt_ff == 2'd3) || frame_last);

   always_ff @(posedge clock) begin
      if (cmd.capture || flush) begin
         pack_ff <= 32'h0000_0000;
      end else if (byte_go) begin
         pack_ff <= word_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pack_cnt_ff  <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.capture || flush) begin
            pack_cnt_ff <= 2'd0;
         end else if (byte_go) begin
            pack_cnt_ff <= cnt_next[1:0];
         end
         if (flush) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (flush) begin
         out_bytes_ff <= word_in;
         out_cnt_ff   <= cnt_next;
         out_eof_ff   <= frame_last;
      end
   end

   always_comb begin
      status.clear_last  = (clr_idx_ff == IDX_LAST);
      status.reduce_last = step_ff;
      status.count_over  = (req_register_count >= 16'(COUNT_LIMIT));
      status.frame_done  = byte_go && frame_last;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_frame_bytes  = out_bytes_ff;
   assign rsp_valid_bytes  = out_cnt_ff;
   assign rsp_end_of_frame = out_eof_ff;

endmodule

FILE: design/modbus_rtu_response_framer.sv
// Modbus RTU response framer. After reset the table is cleared, one entry per cycle,
// with req_stall high. One item at a time; frames move one byte per cycle through the
// CRC while the result output is not stalled, and result stalls hold up emission.
module modbus_rtu_response_framer import mrf_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [7:0]  req_slave_address,
   input  logic [7:0]  req_function_code,
   input  logic [15:0] req_start_address,
   input  logic [15:0] req_register_count,
   input  logic [7:0]  req_load_index,
   input  logic [15:0] req_load_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_frame_bytes,
   output logic [2:0]  rsp_valid_bytes,
   output logic        rsp_end_of_frame
);

   cmd_type    cmd;
   status_type status;

   mrf_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .status        (status),
      .cmd           (cmd),
      .req_stall     (req_stall)
   );

   mrf_dp #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_operation      (req_operation),
      .req_slave_address  (req_slave_address),
      .req_function_code  (req_function_code),
      .req_start_address  (req_start_address),
      .req_register_count (req_register_count),
      .req_load_index     (req_load_index),
      .req_load_value     (req_load_value),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_frame_bytes    (rsp_frame_bytes),
      .rsp_valid_bytes    (rsp_valid_bytes),
      .rsp_end_of_frame   (rsp_end_of_frame)
   );

endmodule

FILE: design/mrf_checker.sv
// Port-level checks on the framer's result channel, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module mrf_port_checks (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_frame_bytes,
   input logic [2:0]  rsp_valid_bytes,
   input logic        rsp_end_of_frame
);

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_frame_bytes) && $stable(rsp_valid_bytes) && $stable(rsp_end_of_frame), "stalled result transfer changed")
   `ASSERT_SAME(a_count_range, clock, reset, rsp_valid, rsp_valid_bytes != 3'd0 && rsp_valid_bytes <= 3'd4, "byte count out of range")
   `ASSERT_SAME(a_full_mid, clock, reset, rsp_valid && !rsp_end_of_frame, rsp_valid_bytes == 3'd4, "short result before frame end")
   `ASSERT_SAME(a_lane_zero, clock, reset, rsp_valid && rsp_valid_bytes == 3'd1, rsp_frame_bytes[23:0] == 24'h000000, "unused byte lanes not zero")

endmodule

bind modbus_rtu_response_framer mrf_port_checks u_mrf_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_frame_bytes  (rsp_frame_bytes),
   .rsp_valid_bytes  (rsp_valid_bytes),
   .rsp_end_of_frame (rsp_end_of_frame)
);

FILE: dv/mrf_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the Modbus RTU response framer: mirrors the holding-register table,
// builds every expected response frame with its CRC and compares the packed result words.
// Depends on mrf_pkg for the operation codes, the count limit and the CRC constants.
module mrf_checker import mrf_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [7:0]  req_slave_address,
   input  logic [7:0]  req_function_code,
   input  logic [15:0] req_start_address,
   input  logic [15:0] req_register_count,
   input  logic [7:0]  req_load_index,
   input  logic [15:0] req_load_value,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [31:0] rsp_frame_bytes,
   input  logic [2:0]  rsp_valid_bytes,
   input  logic        rsp_end_of_frame,
   output int unsigned mismatch_count,
   output int unsigned pending_words,
   output int unsigned words_checked,
   output int unsigned frames_checked
);

   typedef struct packed {
      logic [31:0] data;
      logic [2:0]  nbytes;
      logic        eof;
   } frame_word_type;

   frame_word_type expected_words[$];
   logic [7:0]  frame_buf[$];
   logic [15:0] holding_regs[TABLE_DEPTH];
   int unsigned bad_words;
   int unsigned words_seen;
   int unsigned frames_seen;

   // Append CRC-16/MODBUS low byte first, then pack the frame four bytes per word.
   task automatic close_frame();
      logic [15:0] crc;
      frame_word_type word;
      int n;
      crc = CRC_INIT;
      foreach (frame_buf[i]) begin
         crc[7:0] = crc[7:0] ^ frame_buf[i];
         repeat (8) crc = (crc >> 1) ^ (crc[0] ? CRC_POLY : 16'h0000);
      end
      frame_buf.push_back(crc[7:0]);
      frame_buf.push_back(crc[15:8]);
      n = frame_buf.size();
      for (int pos = 0; pos < n; pos += 4) begin
         word = '0;
         for (int k = 0; k < 4 && pos + k < n; k++) begin
            word.data[31 - 8 * k -: 8] = frame_buf[pos + k];
            word.nbytes = word.nbytes + 3'd1;
         end
         word.eof = (pos + 4 >= n);
         expected_words.push_back(word);
      end
   endtask

   always @(posedge clock) begin : monitor
      frame_word_type got;
      frame_word_type want;
      logic [15:0] reg_word;
      if (reset) begin
         foreach (holding_regs[i]) holding_regs[i] = '0;
         expected_words.delete();
         bad_words = 0;
         words_seen = 0;
         frames_seen = 0;
      end else begin
         // Results can never leave at the edge that takes their request: compare first.
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_frame_bytes, rsp_valid_bytes, rsp_end_of_frame};
            words_seen++;
            if (expected_words.size() == 0) begin
               bad_words++;
               if (bad_words <= 10)
                  $display("result %0d unexpected: bytes %h count %0d eof %0b",
                           words_seen, got.data, got.nbytes, got.eof);
            end else begin
               want = expected_words.pop_front();
               if (want.eof) frames_seen++;
               if (got !== want) begin
                  bad_words++;
                  if (bad_words <= 10)
                     $display({"result %0d mismatch: expected bytes %h count %0d eof %0b,",
                               " got bytes %h count %0d eof %0b"},
                              words_seen, want.data, want.nbytes, want.eof,
                              got.data, got.nbytes, got.eof);
               end
            end
         end

         if (req_valid && !req_stall) begin
            frame_buf.delete();
            unique case (req_operation)
               OP_LOAD: begin
                  holding_regs[int'(req_load_index) % TABLE_DEPTH] = req_load_value;
               end
               OP_READ: begin
                  if (req_register_count < COUNT_LIMIT) begin
                     frame_buf.push_back(req_slave_address);
                     frame_buf.push_back(req_function_code);
                     frame_buf.push_back({req_register_count[6:0], 1'b0});
                     for (int i = 0; i < int'(req_register_count); i++) begin
                        reg_word = holding_regs[(int'(req_start_address) + i) % TABLE_DEPTH];
                        frame_buf.push_back(reg_word[15:8]);
                        frame_buf.push_back(reg_word[7:0]);
                     end
                     close_frame();
                  end
               end
               OP_WRITE: begin
                  frame_buf.push_back(req_slave_address);
                  frame_buf.push_back(req_function_code);
                  frame_buf.push_back(req_start_address[15:8]);
                  frame_buf.push_back(req_start_address[7:0]);
                  frame_buf.push_back(req_register_count[15:8]);
                  frame_buf.push_back(req_register_count[7:0]);
                  close_frame();
               end
               default: ;
            endcase
         end
      end
      mismatch_count <= bad_words;
      pending_words  <= expected_words.size();
      words_checked  <= words_seen;
      frames_checked <= frames_seen;
   end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// Top of the framer testbench: clock, reset, request and response drivers, watchdog, verdict.
// Depends on mrf_pkg, modbus_rtu_response_framer and mrf_checker.
module testbench;
   import mrf_pkg::*;

   localparam int TABLE_DEPTH = TABLE_DEPTH_DEF;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS     = 440;
   localparam int LONG_HOLD_AT     = 150;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES     = 300;
   localparam int WATCHDOG_LIMIT   = 4000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_operation = '0;
   logic [7:0]  req_slave_address = '0;
   logic [7:0]  req_function_code = '0;
   logic [15:0] req_start_address = '0;
   logic [15:0] req_register_count = '0;
   logic [7:0]  req_load_index = '0;
   logic [15:0] req_load_value = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_frame_bytes;
   logic [2:0]  rsp_valid_bytes;
   logic        rsp_end_of_frame;

   int unsigned mismatch_count;
   int unsigned pending_words;
   int unsigned words_checked;
   int unsigned frames_checked;

   bit          sender_idle = 1'b1;
   int unsigned quiet_cycles = 0;
   int unsigned n_load = 0;
   int unsigned n_read = 0;
   int unsigned n_over = 0;
   int unsigned n_write = 0;
   int unsigned n_ignored = 0;

   modbus_rtu_response_framer #(.TABLE_DEPTH(TABLE_DEPTH)) u_dut (.*);

   mrf_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_checker (.*);

   always #10 clock = ~clock;

   // Offer one request, after a random gap when sender_idle is set, and hold it until the transfer.
   task automatic offer_item(input logic [1:0] op, input logic [7:0] addr,
                             input logic [7:0] func, input logic [15:0] start,
                             input logic [15:0] cnt, input logic [7:0] idx,
                             input logic [15:0] value);
      int gap;
      gap = sender_idle ? int'($urandom_range(0, 5)) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_operation      <= op;
      req_slave_address  <= addr;
      req_function_code  <= func;
      req_start_address  <= start;
      req_register_count <= cnt;
      req_load_index     <= idx;
      req_load_value     <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      unique case (op)
         OP_LOAD:  n_load++;
         OP_READ: begin
            if (cnt >= COUNT_LIMIT) n_over++;
            else n_read++;
         end
         OP_WRITE: n_write++;
         default:  n_ignored++;
      endcase
   endtask

   initial begin : stimulus
      int pick;
      int sent;
      logic [1:0]  op;
      logic [15:0] cnt;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Zero-count read of the freshly cleared table.
      offer_item(OP_READ,  8'h00, 8'h00, 16'h0000, 16'd0,     8'h00, 16'h0000);
      offer_item(OP_LOAD,  8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF,  8'h00, 16'hFFFF);
      offer_item(OP_LOAD,  8'h00, 8'h00, 16'h0000, 16'h0000,  8'hFF, 16'h8001);
      offer_item(OP_LOAD,  8'h5A, 8'hA5, 16'h00FF, 16'h0003,  8'h01, 16'h1234);
      offer_item(OP_LOAD,  8'h00, 8'h00, 16'h0000, 16'h0000,  8'hFE, 16'hA5A5);
      offer_item(OP_LOAD,  8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF,  8'h80, 16'h0000);
      // Reads, including ones that wrap around the end of the table and around the 16-bit start.
      offer_item(OP_READ,  8'h01, 8'h03, 16'h00FE, 16'd4,     8'h00, 16'h0000);
      offer_item(OP_READ,  8'hFF, 8'h03, 16'hFFFF, 16'd3,     8'hFF, 16'hFFFF);
      offer_item(OP_READ,  8'hFF, 8'hFF, 16'h0000, 16'd1,     8'h00, 16'h0000);
      offer_item(OP_READ,  8'h11, 8'h03, 16'h0080, 16'(COUNT_LIMIT - 1), 8'h00, 16'h0000);
      // At and above the count limit: no frame.
      offer_item(OP_READ,  8'h22, 8'h03, 16'h0000, 16'(COUNT_LIMIT), 8'h00, 16'h0000);
      offer_item(OP_READ,  8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF,  8'hFF, 16'hFFFF);
      offer_item(OP_UNUSED, 8'hFF, 8'hFF, 16'hFFFF, 16'h0001, 8'hFF, 16'hFFFF);
      offer_item(OP_UNUSED, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'h00, 16'h0000);
      offer_item(OP_WRITE, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF,  8'hFF, 16'hFFFF);
      offer_item(OP_WRITE, 8'h00, 8'h00, 16'h0000, 16'h0000,  8'h00, 16'h0000);
      offer_item(OP_WRITE, 8'h01, 8'h10, 16'h1234, 16'h0070,  8'h33, 16'hBEEF);
      offer_item(OP_READ,  8'hFF, 8'hFF, 16'hFFFF, 16'd0,     8'hFF, 16'hFFFF);
      offer_item(OP_READ,  8'h07, 8'h04, 16'h00FF, 16'd2,     8'h00, 16'h0000);
      offer_item(OP_LOAD,  8'h00, 8'h00, 16'h0000, 16'h0000,  8'hFF, 16'h0000);
      offer_item(OP_READ,  8'h07, 8'h04, 16'hFEFF, 16'd1,     8'h00, 16'h0000);

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         // Switch at random between stretches with and without gaps.
         if (sent % 40 == 0) sender_idle = 1'($urandom_range(0, 1));
         pick = int'($urandom_range(0, 99));
         op = pick < 30 ? OP_LOAD : pick < 68 ? OP_READ : pick < 96 ? OP_WRITE : OP_UNUSED;
         cnt = 16'($urandom_range(0, 65535));
         if (op == OP_READ) begin
            pick = int'($urandom_range(0, 99));
            if (pick < 60) cnt = 16'($urandom_range(0, 6));
            else if (pick < 80) cnt = 16'($urandom_range(7, 40));
            else if (pick < 88) cnt = 16'($urandom_range(41, COUNT_LIMIT - 1));
            else if (pick < 92) cnt = 16'(COUNT_LIMIT - 1);
            else if (pick < 96) cnt = 16'(COUNT_LIMIT);
         end
         offer_item(op, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    16'($urandom_range(0, 65535)), cnt, 8'($urandom_range(0, 255)),
                    16'($urandom_range(0, 65535)));
         sent++;
      end
      req_valid <= 1'b0;

      // Let the checker see the last transfer before polling what it still owes.
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display({"covered %0d loads, %0d read responses, %0d over-limit reads,",
                " %0d write echoes, %0d unused codes"},
               n_load, n_read, n_over, n_write, n_ignored);
      $display("compared %0d result words in %0d frames: %0d mismatches, %0d words still owed",
               words_checked, frames_checked, mismatch_count, pending_words);
      if (mismatch_count == 0 && pending_words == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin : receiver
      int hold;
      int unsigned taken;
      bit idle_on;
      taken = 0;
      idle_on = 1'b1;
      forever begin
         if (taken % 50 == 0) idle_on = 1'($urandom_range(0, 1));
         hold = idle_on ? int'($urandom_range(0, 5)) : 0;
         // Hold off long enough for the block to back up and stall its input.
         if (taken == LONG_HOLD_AT) hold = LONG_HOLD_CYCLES;
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         taken++;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
         $display("status: fail");
         $finish;
      end
   end

endmodule
